FILE: src/vrsu_pkg.sv
package vrsu_pkg;

  // Default configuration
  localparam int COORD_FRAC_BITS_DEF  = 16;
  localparam int TRIG_TABLE_DEPTH_DEF = 1024;

  // One full turn in degrees, and its odd factor (360 = 45 * 8)
  localparam int DEG_FULL = 360;
  localparam int FULL_ODD = DEG_FULL / 8;

  localparam int COORD_W = 32;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_SUB    = 3'd1,
    ACT_ROT_XY = 3'd2,
    ACT_ROT_YZ = 3'd3,
    ACT_ROT_XZ = 3'd4,
    ACT_SCALE  = 3'd5
  } act_e;

  typedef struct packed {
    act_e   action;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
  } item_t;

  // Sine/cosine generation (elaboration time only)
  localparam int     CORDIC_STEPS    = 30;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
  localparam longint QUARTER_TURN    = 64'sh0000_0000_4000_0000;
  localparam longint HALF_TURN       = 64'sh0000_0000_8000_0000;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  // Returns {sin, cos} in Q2.30 for a binary angle (low 32 bits used)
  function automatic logic [63:0] trig_entry(input longint turns);
    longint t;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic   flip;
    int     i;
    t    = longint'($signed(turns[31:0]));
    flip = 1'b0;
    if (t > QUARTER_TURN) begin
      t    = t - HALF_TURN;
      flip = 1'b1;
    end else if (t < -QUARTER_TURN) begin
      t    = t + HALF_TURN;
      flip = 1'b1;
    end
    x = CORDIC_GAIN_Q30;
    y = 0;
    z = t;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURNS[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return {y[31:0], x[31:0]};
  endfunction

endpackage

FILE: src/vector3_rotate_scale_unit_core.sv
// 3D vector add / subtract / plane rotate / per-axis scale, 9-stage pipeline.
// One word per cycle sustained while the output side is not stalled.
// Depth is set by the angle-reduction chain, trig ROM read and multipliers.
// Each stage holds a valid bit and collapses bubbles, so stalls on the output
// side only back up as far as the first empty stage.
// Reset (rst_ni low, async) clears only the stage valid bits; data is unreset.
module vector3_rotate_scale_unit_core #(
  parameter int COORD_FRAC_BITS  = vrsu_pkg::COORD_FRAC_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = vrsu_pkg::TRIG_TABLE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       action_i,
  input  vrsu_pkg::coord_t a_x_i,
  input  vrsu_pkg::coord_t a_y_i,
  input  vrsu_pkg::coord_t a_z_i,
  input  vrsu_pkg::coord_t b_x_i,
  input  vrsu_pkg::coord_t b_y_i,
  input  vrsu_pkg::coord_t b_z_i,
  input  vrsu_pkg::coord_t angle_deg_i,
  // result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output vrsu_pkg::coord_t r_x_o,
  output vrsu_pkg::coord_t r_y_o,
  output vrsu_pkg::coord_t r_z_o,
  output logic             overflow_o
);
  import vrsu_pkg::*;

  // Pipeline map:
  //   1 input regs          2 u_hi / 45 estimate    3 angle mod 360 (m)
  //   4 Y = scaled m        5 Y / 45 estimate       6 table index p
  //   7 trig ROM read       8 products              9 round, saturate, out
  localparam int NUM_STAGES = 9;
  localparam int PL_LAST    = 8;

  // Angle reduction constants. The full circle is 360 << F = 45 << SH.
  localparam int     SH      = COORD_FRAC_BITS + 3;
  localparam int     K1      = COORD_W - SH;          // width of angle bits above SH
  localparam int     M_W     = SH + 6;                // holds m < 45 << SH
  localparam int     DW      = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int     PW      = $clog2(TRIG_TABLE_DEPTH);
  localparam int     Y_W     = DW + 6;
  localparam longint Full    = longint'(DEG_FULL) << COORD_FRAC_BITS;
  localparam longint FullHalf = Full / 2;
  // the input angle is offset by 2^31 to work unsigned; this undoes it
  localparam longint OffMod  = (longint'(1) << 31) % Full;
  localparam logic [K1-1:0]  Recip1 = K1'((longint'(1) << K1) / FULL_ODD);
  localparam logic [Y_W-1:0] Recip2 = Y_W'((longint'(1) << Y_W) / FULL_ODD);

  localparam logic signed [63:0] RotHalf = 64'sh2000_0000;
  localparam logic signed [63:0] SclHalf = 64'sd1 <<< (COORD_FRAC_BITS - 1);

  // ---------------------------------------------------------------
  // Handshake: stage k may load when empty or when it drains forward
  // ---------------------------------------------------------------
  logic [NUM_STAGES:1] vld_q;
  logic [NUM_STAGES:1] go;

  always_comb begin
    go[NUM_STAGES] = !vld_q[NUM_STAGES] || out_ready_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      go[k] = !vld_q[k] || go[k+1];
    end
  end

  assign in_ready_o  = go[1];
  assign out_valid_o = vld_q[NUM_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (go[1]) begin
        vld_q[1] <= in_valid_i;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (go[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Operand word travels alongside the angle path
  item_t pl_q [1:PL_LAST];

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      pl_q[1] <= '{action: act_e'(action_i), ax: a_x_i, ay: a_y_i, az: a_z_i,
                   bx: b_x_i, by: b_y_i, bz: b_z_i};
    end
    for (int k = 2; k <= PL_LAST; k++) begin
      if (go[k]) begin
        pl_q[k] <= pl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1 -> 2: offset angle, estimate floor(u_hi / 45)
  // ---------------------------------------------------------------
  coord_t              ang_q;
  logic [COORD_W-1:0]  u_d;
  logic [COORD_W-1:0]  u_q;
  logic [2*K1-1:0]     q1_prod;
  logic [K1-1:0]       q1_q;

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      ang_q <= angle_deg_i;
    end
  end

  always_comb begin
    u_d     = {~ang_q[COORD_W-1], ang_q[COORD_W-2:0]};
    q1_prod = (2*K1)'(u_d[COORD_W-1:SH]) * (2*K1)'(Recip1);
  end

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      u_q  <= u_d;
      q1_q <= q1_prod[2*K1-1:K1];
    end
  end

  // ---------------------------------------------------------------
  // Stage 2 -> 3: m = angle mod full circle, in [0, full)
  // ---------------------------------------------------------------
  logic [K1:0]    r1_raw;
  logic [K1:0]    r1;
  logic [M_W-1:0] m1;
  logic [M_W-1:0] m_d;
  logic [M_W-1:0] m_q;

  always_comb begin
    r1_raw = (K1+1)'(u_q[COORD_W-1:SH]) - (K1+1)'(q1_q) * (K1+1)'(FULL_ODD);
    r1     = (r1_raw >= (K1+1)'(FULL_ODD)) ? r1_raw - (K1+1)'(FULL_ODD) : r1_raw;
    m1     = {r1[5:0], u_q[SH-1:0]};
    m_d    = (m1 >= M_W'(OffMod)) ? m1 - M_W'(OffMod) : m1 + M_W'(Full - OffMod);
  end

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      m_q <= m_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3 -> 4: Y = (m * depth + full/2) >> SH, so p = floor(Y / 45)
  // ---------------------------------------------------------------
  logic [M_W+DW-1:0] md;
  logic [Y_W-1:0]    y_q;

  always_comb begin
    md = (M_W+DW)'(m_q) * (M_W+DW)'(TRIG_TABLE_DEPTH) + (M_W+DW)'(FullHalf);
  end

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      y_q <= md[M_W+DW-1:SH];
    end
  end

  // ---------------------------------------------------------------
  // Stage 4 -> 5: estimate floor(Y / 45)
  // ---------------------------------------------------------------
  logic [2*Y_W-1:0] q2_prod;
  logic [Y_W-1:0]   q2_q;
  logic [Y_W-1:0]   y2_q;

  always_comb begin
    q2_prod = (2*Y_W)'(y_q) * (2*Y_W)'(Recip2);
  end

  always_ff @(posedge clk_i) begin
    if (go[5]) begin
      q2_q <= q2_prod[2*Y_W-1:Y_W];
      y2_q <= y_q;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5 -> 6: correct estimate, wrap top step to zero
  // ---------------------------------------------------------------
  logic [Y_W:0]   r2;
  logic [Y_W-1:0] pn;
  logic [PW-1:0]  p_d;
  logic [PW-1:0]  p_q;

  always_comb begin
    r2  = (Y_W+1)'(y2_q) - (Y_W+1)'(q2_q) * (Y_W+1)'(FULL_ODD);
    pn  = (r2 >= (Y_W+1)'(FULL_ODD)) ? q2_q + Y_W'(1) : q2_q;
    p_d = (pn == Y_W'(TRIG_TABLE_DEPTH)) ? '0 : pn[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (go[6]) begin
      p_q <= p_d;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6 -> 7: sine/cosine ROM, {sin, cos} Q2.30 per step
  // ---------------------------------------------------------------
  logic [63:0] trig_rom [TRIG_TABLE_DEPTH];
  logic [63:0] sc_q;

  for (genvar g = 0; g < TRIG_TABLE_DEPTH; g++) begin : g_rom
    localparam longint Turns = ((longint'(g) << 32) + longint'(TRIG_TABLE_DEPTH / 2))
                               / longint'(TRIG_TABLE_DEPTH);
    assign trig_rom[g] = trig_entry(Turns);
  end

  always_ff @(posedge clk_i) begin
    if (go[7]) begin
      sc_q <= trig_rom[p_q];
    end
  end

  // ---------------------------------------------------------------
  // Stage 7 -> 8: four shared 32x32 multipliers
  //   rotate: u*c, v*s, u*s, v*c    scale: ax*bx, ay*by, az*bz
  // ---------------------------------------------------------------
  coord_t              sin_v;
  coord_t              cos_v;
  coord_t              rot_u;
  coord_t              rot_v;
  coord_t              op_a [4];
  coord_t              op_b [4];
  logic signed [63:0]  prod_q [4];

  always_comb begin
    sin_v = $signed(sc_q[63:32]);
    cos_v = $signed(sc_q[31:0]);
    rot_u = pl_q[7].ax;
    rot_v = pl_q[7].ay;
    unique case (pl_q[7].action)
      ACT_ROT_YZ: begin
        rot_u = pl_q[7].ay;
        rot_v = pl_q[7].az;
      end
      ACT_ROT_XZ: begin
        rot_u = pl_q[7].az;
        rot_v = pl_q[7].ax;
      end
      default: begin
        rot_u = pl_q[7].ax;
        rot_v = pl_q[7].ay;
      end
    endcase

    if (pl_q[7].action == ACT_SCALE) begin
      op_a[0] = pl_q[7].ax;  op_b[0] = pl_q[7].bx;
      op_a[1] = pl_q[7].ay;  op_b[1] = pl_q[7].by;
      op_a[2] = pl_q[7].az;  op_b[2] = pl_q[7].bz;
      op_a[3] = '0;          op_b[3] = '0;
    end else begin
      op_a[0] = rot_u;  op_b[0] = cos_v;
      op_a[1] = rot_v;  op_b[1] = sin_v;
      op_a[2] = rot_u;  op_b[2] = sin_v;
      op_a[3] = rot_v;  op_b[3] = cos_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[8]) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= 64'(op_a[k]) * 64'(op_b[k]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 8 -> 9: round half up, saturate, select by action
  // ---------------------------------------------------------------
  function automatic logic sat_hit(input logic signed [63:0] v);
    return !((&v[63:31]) || !(|v[63:31]));
  endfunction

  function automatic coord_t sat_val(input logic signed [63:0] v);
    if (sat_hit(v)) begin
      return v[63] ? COORD_MIN : COORD_MAX;
    end
    return $signed(v[31:0]);
  endfunction

  item_t              it;
  logic signed [63:0] rot0;
  logic signed [63:0] rot1;
  logic signed [63:0] scl [3];
  logic signed [63:0] sum [3];
  logic signed [63:0] dif [3];
  coord_t             rx_d;
  coord_t             ry_d;
  coord_t             rz_d;
  logic               ovf_d;
  coord_t             rx_q;
  coord_t             ry_q;
  coord_t             rz_q;
  logic               ovf_q;

  always_comb begin
    it   = pl_q[PL_LAST];
    rot0 = (prod_q[0] - prod_q[1] + RotHalf) >>> 30;
    rot1 = (prod_q[2] + prod_q[3] + RotHalf) >>> 30;
    for (int k = 0; k < 3; k++) begin
      scl[k] = (prod_q[k] + SclHalf) >>> COORD_FRAC_BITS;
    end
    sum[0] = 64'(it.ax) + 64'(it.bx);
    sum[1] = 64'(it.ay) + 64'(it.by);
    sum[2] = 64'(it.az) + 64'(it.bz);
    dif[0] = 64'(it.ax) - 64'(it.bx);
    dif[1] = 64'(it.ay) - 64'(it.by);
    dif[2] = 64'(it.az) - 64'(it.bz);

    // unused codes pass a through
    rx_d  = it.ax;
    ry_d  = it.ay;
    rz_d  = it.az;
    ovf_d = 1'b0;
    unique case (it.action)
      ACT_ADD: begin
        rx_d  = sat_val(sum[0]);
        ry_d  = sat_val(sum[1]);
        rz_d  = sat_val(sum[2]);
        ovf_d = sat_hit(sum[0]) || sat_hit(sum[1]) || sat_hit(sum[2]);
      end
      ACT_SUB: begin
        rx_d  = sat_val(dif[0]);
        ry_d  = sat_val(dif[1]);
        rz_d  = sat_val(dif[2]);
        ovf_d = sat_hit(dif[0]) || sat_hit(dif[1]) || sat_hit(dif[2]);
      end
      ACT_ROT_XY: begin
        rx_d  = sat_val(rot0);
        ry_d  = sat_val(rot1);
        ovf_d = sat_hit(rot0) || sat_hit(rot1);
      end
      ACT_ROT_YZ: begin
        ry_d  = sat_val(rot0);
        rz_d  = sat_val(rot1);
        ovf_d = sat_hit(rot0) || sat_hit(rot1);
      end
      ACT_ROT_XZ: begin
        // pair is (z, x): first output is z'
        rz_d  = sat_val(rot0);
        rx_d  = sat_val(rot1);
        ovf_d = sat_hit(rot0) || sat_hit(rot1);
      end
      ACT_SCALE: begin
        rx_d  = sat_val(scl[0]);
        ry_d  = sat_val(scl[1]);
        rz_d  = sat_val(scl[2]);
        ovf_d = sat_hit(scl[0]) || sat_hit(scl[1]) || sat_hit(scl[2]);
      end
      default: begin
        ovf_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (go[NUM_STAGES]) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      rz_q  <= rz_d;
      ovf_q <= ovf_d;
    end
  end

  assign r_x_o      = rx_q;
  assign r_y_o      = ry_q;
  assign r_z_o      = rz_q;
  assign overflow_o = ovf_q;

endmodule
